[hdl/dfir_pkg.sv]
`default_nettype none

package dfir_pkg;

    // Fixed field widths
    localparam int DATA_W      = 16;
    localparam int TAP_INDEX_W = 6;
    localparam int TAPS_CFG_W  = 7;
    localparam int DEC_CFG_W   = 5;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int FRAC_W      = DATA_W - 1;

    // Rounding and saturation constants for Q2.30 -> Q1.15
    localparam int ROUND_BIAS = 16384;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    // Reset values of the configuration registers
    localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 7'd64;
    localparam logic [DEC_CFG_W-1:0]  DEC_RESET  = 5'd1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAPS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIM = 2'd1;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Control to every cell of the chain
    typedef struct packed {
        logic sample_shift;   // shift a new sample into the delay line
        logic coef_write;     // write one coefficient
        logic load;           // copy delay line and coefficients into work chains
        logic work_shift;     // advance the sample work chain
        logic coef_shift;     // advance the coefficient work chain
    } cell_ctrl_t;

    // Control to the multiply-accumulate unit
    typedef struct packed {
        logic clear;          // start a new sum
        logic mul_en;         // multiply the head of both work chains
    } mac_ctrl_t;

endpackage

`default_nettype wire

[hdl/decimating_fir_filter.sv]
// Decimating FIR filter, Q1.15 samples and coefficients.
//
// Input channel (in_valid/in_ready): kind 1 writes value into coefficient
// tap_index; kind 0 shifts value into the delay line. Samples 0, D, 2D, ...
// after reset each produce one beat on the output channel
// (out_valid/out_ready, filtered_sample), rounded half-up and saturated.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = taps in use, 1 = decimation factor); write only while idle.
//
// A coefficient write or a sample without output leaves in_ready high. A sample
// that produces an output walks the work chains through all MAX_TAPS cells
// into one shared multiplier, through states RUN, DRAIN and FINISH; its
// result is registered once the output register is free, and in_ready
// returns in that same cycle. Throughput is thus set by the chain length:
// no input is accepted while an output is being computed.
// Reset clears the delay line, coefficients, decimation phase and output
// valid, and sets taps in use to 64 and decimation to 1.
// A stalled receiver holds the result in the output register; input is
// still accepted, and a following result waits in the sequencer with
// in_ready low until the register frees.
`default_nettype none

module decimating_fir_filter #(
    parameter int MAX_TAPS       = 64,
    parameter int MAX_DECIMATION = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic                                       kind,
    input  wire logic [dfir_pkg::TAP_INDEX_W-1:0]           tap_index,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         value,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic signed [dfir_pkg::DATA_W-1:0]              filtered_sample,
    input  wire logic                                       cfg_we,
    input  wire logic [dfir_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  wire logic [dfir_pkg::CFG_DATA_W-1:0]            cfg_data
);
    import dfir_pkg::*;

    localparam int CW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int EW     = $clog2(MAX_TAPS + 1);
    localparam int TW     = (EW > TAPS_CFG_W) ? EW : TAPS_CFG_W;
    localparam int PW     = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
    localparam int DEW    = $clog2(MAX_DECIMATION + 1) + 1;
    localparam int DW     = (DEW > DEC_CFG_W) ? DEW : DEC_CFG_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic [PW-1:0]            phase_reg;
    logic [PW-1:0]            phase_next;
    logic [TAPS_CFG_W-1:0]    taps_reg;
    logic [DEC_CFG_W-1:0]     dec_reg;
    logic                     ovalid_reg;
    logic                     ovalid_next;
    logic signed [DATA_W-1:0] osample_reg;
    logic signed [DATA_W-1:0] osample_next;

    logic                     in_fire;
    logic                     sample_fire;
    logic                     emit;
    logic [TW-1:0]            taps_ext;
    logic [EW-1:0]            eff_taps;
    logic [EW-1:0]            start_cnt;
    logic                     active;
    logic [DW-1:0]            dec_ext;
    logic [DW-1:0]            eff_dec;
    logic [DW-1:0]            phase_inc;
    logic                     out_free;

    cell_ctrl_t               cell_ctrl;
    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mac_result;

    logic signed [DATA_W-1:0] delay_q  [MAX_TAPS];
    logic signed [DATA_W-1:0] delay_nx [MAX_TAPS];
    logic signed [DATA_W-1:0] wsamp    [MAX_TAPS];
    logic signed [DATA_W-1:0] wcoef    [MAX_TAPS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_RESET;
            dec_reg  <= DEC_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TAPS)
            begin
                taps_reg <= cfg_data[TAPS_CFG_W-1:0];
            end
            else if (cfg_index == REG_DECIM)
            begin
                dec_reg <= cfg_data[DEC_CFG_W-1:0];
            end
        end
    end

    // Clamp the window length and decimation factor
    assign taps_ext = TW'(taps_reg);
    assign dec_ext  = DW'(dec_reg);

    always_comb
    begin
        if (taps_ext == '0)
        begin
            eff_taps = EW'(1);
        end
        else if (taps_ext > TW'(MAX_TAPS))
        begin
            eff_taps = EW'(MAX_TAPS);
        end
        else
        begin
            eff_taps = EW'(taps_ext);
        end

        if (dec_ext == '0)
        begin
            eff_dec = DW'(1);
        end
        else if (dec_ext > DW'(MAX_DECIMATION))
        begin
            eff_dec = DW'(MAX_DECIMATION);
        end
        else
        begin
            eff_dec = dec_ext;
        end
    end

    // Input handshake
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign sample_fire = in_fire && (kind == KIND_SAMPLE);
    assign emit        = sample_fire && (phase_reg == '0);

    // Advance the decimation phase, wrapping at the factor
    assign phase_inc = DW'(phase_reg) + DW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (sample_fire)
        begin
            if (phase_inc >= eff_dec)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = PW'(phase_inc);
            end
        end
    end

    // Products count once the sample chain reaches the window's oldest entry
    assign start_cnt = EW'(MAX_TAPS) - eff_taps;
    assign active    = (state_reg == ST_RUN) && (EW'(cnt_reg) >= start_cnt);

    assign out_free  = !ovalid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovalid_next  = ovalid_reg;
        osample_next = osample_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == CW'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    osample_next = mac_result;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            phase_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osample_reg <= osample_next;
    end

    assign out_valid       = ovalid_reg;
    assign filtered_sample = osample_reg;

    // Cell and MAC control
    always_comb
    begin
        cell_ctrl.sample_shift = sample_fire;
        cell_ctrl.coef_write   = in_fire && (kind == KIND_COEF);
        cell_ctrl.load         = emit;
        cell_ctrl.work_shift   = (state_reg == ST_RUN);
        cell_ctrl.coef_shift   = active;
        mac_ctrl.clear         = emit;
        mac_ctrl.mul_en        = active;
    end

    // Row of cells: delay line shifts up, work chains drain toward cell 0
    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        logic signed [DATA_W-1:0] d_in;
        logic signed [DATA_W-1:0] ws_in;
        logic signed [DATA_W-1:0] wc_in;

        if (j == 0)
        begin : g_head
            assign d_in = value;
        end
        else
        begin : g_body
            assign d_in = delay_q[j-1];
        end

        if (j == MAX_TAPS - 1)
        begin : g_tail
            assign ws_in = '0;
            assign wc_in = '0;
        end
        else
        begin : g_link
            assign ws_in = wsamp[j+1];
            assign wc_in = wcoef[j+1];
        end

        dfir_cell #(
            .CELL_IDX (j)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (cell_ctrl),
            .delay_in        (d_in),
            .delay_q         (delay_q[j]),
            .delay_nx        (delay_nx[j]),
            .load_sample     (delay_nx[MAX_TAPS-1-j]),
            .work_sample_in  (ws_in),
            .work_sample_out (wsamp[j]),
            .work_coef_in    (wc_in),
            .work_coef_out   (wcoef[j]),
            .wr_index        (tap_index),
            .wr_value        (value)
        );
    end

    // Shared multiply-accumulate at the head of the chain
    dfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (wsamp[0]),
        .coef   (wcoef[0]),
        .result (mac_result)
    );

endmodule

`default_nettype wire

[hdl/dfir_cell.sv]
`default_nettype none

module dfir_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire dfir_pkg::cell_ctrl_t                       ctrl,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         delay_in,
    output logic signed [dfir_pkg::DATA_W-1:0]              delay_q,
    output logic signed [dfir_pkg::DATA_W-1:0]              delay_nx,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         load_sample,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         work_sample_in,
    output logic signed [dfir_pkg::DATA_W-1:0]              work_sample_out,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         work_coef_in,
    output logic signed [dfir_pkg::DATA_W-1:0]              work_coef_out,
    input  wire logic [dfir_pkg::TAP_INDEX_W-1:0]           wr_index,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]         wr_value
);
    import dfir_pkg::*;

    localparam logic [31:0] MY_IDX = 32'(CELL_IDX);

    logic signed [DATA_W-1:0] delay_reg;
    logic signed [DATA_W-1:0] coef_reg;
    logic signed [DATA_W-1:0] coef_next;
    logic signed [DATA_W-1:0] wsamp_reg;
    logic signed [DATA_W-1:0] wsamp_next;
    logic signed [DATA_W-1:0] wcoef_reg;
    logic signed [DATA_W-1:0] wcoef_next;
    logic                     wr_hit;

    // Shift the delay line on a sample beat
    assign delay_nx = ctrl.sample_shift ? delay_in : delay_reg;

    // Store a coefficient addressed to this cell
    assign wr_hit    = ctrl.coef_write && (32'(wr_index) == MY_IDX);
    assign coef_next = wr_hit ? wr_value : coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            coef_reg  <= '0;
        end
        else
        begin
            delay_reg <= delay_nx;
            coef_reg  <= coef_next;
        end
    end

    // Load or advance the work chains
    always_comb
    begin
        wsamp_next = wsamp_reg;
        wcoef_next = wcoef_reg;
        if (ctrl.load)
        begin
            wsamp_next = load_sample;
            wcoef_next = coef_reg;
        end
        else
        begin
            if (ctrl.work_shift)
            begin
                wsamp_next = work_sample_in;
            end
            if (ctrl.coef_shift)
            begin
                wcoef_next = work_coef_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wsamp_reg <= wsamp_next;
        wcoef_reg <= wcoef_next;
    end

    assign delay_q         = delay_reg;
    assign work_sample_out = wsamp_reg;
    assign work_coef_out   = wcoef_reg;

endmodule

`default_nettype wire

[hdl/dfir_mac.sv]
`default_nettype none

module dfir_mac #(
    parameter int ACC_W = 39
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire dfir_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]     sample,
    input  wire logic signed [dfir_pkg::DATA_W-1:0]     coef,
    output logic signed [dfir_pkg::DATA_W-1:0]          result
);
    import dfir_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     pvalid_reg;
    logic                     pvalid_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  scaled;

    // Multiply stage
    assign prod_next   = PROD_W'(sample) * PROD_W'(coef);
    assign pvalid_next = ctrl.mul_en && !ctrl.clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= pvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Accumulate stage, exact sum
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (pvalid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Round half-up to Q1.15 and saturate
    assign rounded = acc_reg + $signed(ACC_W'(ROUND_BIAS));
    assign scaled  = rounded >>> FRAC_W;

    always_comb
    begin
        if (scaled > $signed(ACC_W'(SAT_MAX)))
        begin
            result = DATA_W'(SAT_MAX);
        end
        else if (scaled < $signed(ACC_W'(SAT_MIN)))
        begin
            result = DATA_W'(SAT_MIN);
        end
        else
        begin
            result = scaled[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

[dv/decimating_fir_filter_test.sv]
`timescale 1ns / 1ps

module decimating_fir_filter_test;
    import dfir_pkg::*;

    localparam int MAX_TAPS       = 64;
    localparam int MAX_DECIMATION = 16;
    localparam int HALF_PERIOD    = 4;
    localparam int SETTLE_CYCLES  = 2 * MAX_TAPS;
    localparam int HOLD_CYCLES    = 500;
    localparam int RUN_LIMIT_NS   = 20_000_000;
    localparam int RANDOM_ITEMS   = 1000;

    // Register indexes that the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          kind;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [DATA_W-1:0]      value;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [DATA_W-1:0]      filtered_sample;
    logic                          cfg_we;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    // Shared control between the stimulus and the receiver
    bit                            idle_on;
    bit                            hold_req;
    int                            mismatch_count = 0;

    // Filter state as the testbench sees it
    logic signed [DATA_W-1:0]      hist_line [MAX_TAPS];   // [0] newest
    logic signed [DATA_W-1:0]      coef_bank [MAX_TAPS];
    int unsigned                   dec_phase;
    logic [TAPS_CFG_W-1:0]         taps_cfg;
    logic [DEC_CFG_W-1:0]          dec_cfg;
    logic signed [DATA_W-1:0]      pending_outputs [$];
    logic signed [DATA_W-1:0]      want_sample;

    decimating_fir_filter #(
        .MAX_TAPS       (MAX_TAPS),
        .MAX_DECIMATION (MAX_DECIMATION)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .tap_index       (tap_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Clear the filter state to its reset contents
    function automatic void fir_reset();
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            hist_line[j] = '0;
            coef_bank[j] = '0;
        end
        dec_phase = 0;
        taps_cfg  = TAPS_RESET;
        dec_cfg   = DEC_RESET;
    endfunction

    // Track a register write; undecoded indexes leave everything alone
    function automatic void fir_config(logic [CFG_INDEX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] data);
        if (idx == REG_TAPS)
            taps_cfg = data[TAPS_CFG_W-1:0];
        else if (idx == REG_DECIM)
            dec_cfg = data[DEC_CFG_W-1:0];
    endfunction

    // Advance the filter by one beat and queue the output it makes
    function automatic void fir_predict(logic k, logic [TAP_INDEX_W-1:0] idx,
                                        logic signed [DATA_W-1:0] v);
        longint acc;
        longint q;
        int     t;
        int     d;
        bit     emit;
        if (k == KIND_COEF)
        begin
            if (int'(idx) < MAX_TAPS)
                coef_bank[idx] = v;
            return;
        end
        for (int j = MAX_TAPS - 1; j > 0; j--)
            hist_line[j] = hist_line[j-1];
        hist_line[0] = v;

        // Out-of-range factors clamp into 1 .. MAX_DECIMATION
        d = int'(dec_cfg);
        if (d == 0)
            d = 1;
        else if (d > MAX_DECIMATION)
            d = MAX_DECIMATION;
        emit = (dec_phase == 0);
        dec_phase++;
        if (dec_phase >= d)
            dec_phase = 0;
        if (!emit)
            return;

        t = int'(taps_cfg);
        if (t == 0)
            t = 1;
        else if (t > MAX_TAPS)
            t = MAX_TAPS;
        acc = 0;
        for (int j = 0; j < t; j++)
            acc += longint'(coef_bank[j]) * longint'(hist_line[t-1-j]);

        // Round half-up, then saturate to Q1.15
        q = (acc + ROUND_BIAS) >>> FRAC_W;
        if (q > SAT_MAX)
            q = SAT_MAX;
        else if (q < SAT_MIN)
            q = SAT_MIN;
        pending_outputs.push_back(DATA_W'(q));
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'sh7FFF;
        if (r < 16)
            return 16'sh8000;
        if (r < 20)
            return '0;
        return DATA_W'($urandom);
    endfunction

    // Offer one beat and hold it until accepted; returns at a falling edge
    task automatic send_beat(logic k, logic [TAP_INDEX_W-1:0] idx,
                             logic signed [DATA_W-1:0] v);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        tap_index <= idx;
        value     <= v;
        do
            @(posedge clk);
        while (!in_ready);
        fir_predict(k, idx, v);
        @(negedge clk);
    endtask

    task automatic send_sample(logic signed [DATA_W-1:0] v);
        send_beat(KIND_SAMPLE, TAP_INDEX_W'($urandom), v);
    endtask

    task automatic send_coef(logic [TAP_INDEX_W-1:0] idx, logic signed [DATA_W-1:0] v);
        send_beat(KIND_COEF, idx, v);
    endtask

    // Drop valid, wait for every queued output, then let the block settle
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        fir_config(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] taps, logic [CFG_DATA_W-1:0] dec);
        drain_pipeline();
        write_reg(REG_TAPS, taps);
        write_reg(REG_DECIM, dec);
    endtask

    // Reset contents: zero coefficients give zero outputs whatever the samples
    task automatic test_reset_defaults();
        send_beat(KIND_SAMPLE, 6'd63, 16'sh7FFF);
        send_beat(KIND_SAMPLE, 6'd0, 16'sh8000);
    endtask

    // Coefficients at both ends of the store and both ends of the range
    task automatic test_coefficient_extremes();
        send_coef(6'd63, 16'sh8000);
        send_coef(6'd0, 16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    // Saturate both ways with a two-tap window, then hit the rounding edge
    task automatic test_rounding_and_saturation();
        set_config(7'd2, 7'd1);
        send_coef(6'd0, 16'sh8000);
        send_coef(6'd1, 16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        set_config(7'd1, 7'd1);
        send_coef(6'd0, 16'sh0001);
        send_sample(16'sd16384);
        send_sample(-16'sd16384);
        send_sample(-16'sd16385);
    endtask

    // Window of zero acts as one tap, above the maximum as the full line
    task automatic test_window_limits();
        set_config(7'd0, 7'd1);
        send_sample(pick_value());
        set_config(7'd127, 7'd1);
        send_sample(pick_value());
    endtask

    // Factor of zero acts as one, above the maximum as the maximum
    task automatic test_decimation_limits();
        set_config(7'd64, 7'd0);
        send_sample(pick_value());
        send_sample(pick_value());
        drain_pipeline();
        write_reg(REG_DECIM, 7'h7F);
        send_sample(pick_value());
        send_sample(pick_value());
        drain_pipeline();
        write_reg(REG_DECIM, 7'd17);
        send_sample(pick_value());
    endtask

    // Shrink the factor while the phase is already past it
    task automatic test_decimation_change();
        set_config(7'd64, 7'd1);
        send_sample(pick_value());
        drain_pipeline();
        write_reg(REG_DECIM, 7'd8);
        repeat (5) send_sample(pick_value());
        drain_pipeline();
        write_reg(REG_DECIM, 7'd3);
        send_sample(pick_value());
        send_sample(pick_value());
    endtask

    // Writes to undecoded indexes must not disturb the filter
    task automatic test_unknown_registers();
        drain_pipeline();
        write_reg(REG_SPARE_A, 7'h7F);
        write_reg(REG_SPARE_B, 7'h55);
        send_sample(pick_value());
        send_sample(pick_value());
    endtask

    // Hold the receiver off so the block fills, then pause until it drains
    task automatic test_output_backpressure();
        set_config(7'd64, 7'd1);
        for (int j = 0; j < 8; j++)
            send_coef(TAP_INDEX_W'($urandom), pick_value());
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (12) send_sample(pick_value());
        drain_pipeline();
        idle_on = 1'b1;
    endtask

    // Phases of random settings, each a stream of samples with coefficient writes mixed in
    task automatic test_random_stream(int n_items);
        int                    sent;
        int                    len;
        logic [CFG_DATA_W-1:0] taps;
        logic [CFG_DATA_W-1:0] dec;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 5))
                0:       taps = CFG_DATA_W'($urandom);
                1:       taps = 7'd64;
                2:       taps = 7'd1;
                default: taps = CFG_DATA_W'($urandom_range(1, MAX_TAPS));
            endcase
            case ($urandom_range(0, 5))
                0:       dec = CFG_DATA_W'($urandom);
                1:       dec = 7'd1;
                2:       dec = 7'd16;
                default: dec = CFG_DATA_W'($urandom_range(1, MAX_DECIMATION));
            endcase
            set_config(taps, dec);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
            idle_on = ($urandom_range(0, 4) != 0);
            len = $urandom_range(40, 120);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_coef(TAP_INDEX_W'($urandom), pick_value());
                else
                    send_sample(pick_value());
            end
            sent += len;
        end
        idle_on = 1'b1;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int n;
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                n = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (idle_on)
                n = pick_gap();
            else
                n = 0;
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest queued prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected output beat, expected none, actual %0d",
                         $time, filtered_sample);
            end
            else
            begin
                want_sample = pending_outputs.pop_front();
                if (filtered_sample !== want_sample)
                begin
                    mismatch_count++;
                    $display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
                             $time, want_sample, filtered_sample);
                end
            end
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("** decimating_fir_filter: FAILED **");
        $finish;
    end

    initial
    begin
        in_valid       = 1'b0;
        kind           = KIND_SAMPLE;
        tap_index      = '0;
        value          = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TAPS;
        cfg_data       = '0;
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        fir_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_coefficient_extremes();
        test_rounding_and_saturation();
        test_window_limits();
        test_decimation_limits();
        test_decimation_change();
        test_unknown_registers();
        test_output_backpressure();
        test_random_stream(RANDOM_ITEMS);
        drain_pipeline();

        if (mismatch_count == 0)
            $display("** decimating_fir_filter: PASSED **");
        else
            $display("** decimating_fir_filter: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/dfir_pkg.sv
hdl/dfir_cell.sv
hdl/dfir_mac.sv
hdl/decimating_fir_filter.sv
dv/decimating_fir_filter_test.sv
